[rtl/hfm_pkg.sv]
// ----------------------------------------------------------------------------
// hfm_pkg
// Shared types and constants for the binary16 multiplier.
// ----------------------------------------------------------------------------
package hfm_pkg;

  // binary16 layout
  localparam int unsigned ExpW  = 5;
  localparam int unsigned FracW = 10;
  localparam int unsigned SigW  = FracW + 1;
  localparam int unsigned HalfW = 16;
  localparam int unsigned ProdW = 2 * SigW;

  // Unbiased exponent range of one operand is -24..15, so the sum fits in 7 bits
  localparam int unsigned EW = 7;

  // Rounding mode codes
  localparam logic [1:0] RM_RTZ = 2'd0;
  localparam logic [1:0] RM_RNE = 2'd1;
  localparam logic [1:0] RM_RUP = 2'd2;
  localparam logic [1:0] RM_RDN = 2'd3;
  localparam logic [1:0] RM_RESET = RM_RNE;

  // Fixed result patterns
  localparam logic [15:0] HF_INF         = 16'h7C00;
  localparam logic [15:0] HF_MAX_FINITE  = 16'h7BFF;
  localparam logic [15:0] HF_ZERO_X_INF  = 16'hFE00;

  // Decoded operand
  typedef struct packed {
    logic                 is_nan;
    logic                 is_inf;
    logic                 is_zero;
    logic [SigW-1:0]      sig;   // normalized, bit 10 set for finite nonzero
    logic signed [EW-1:0] expo;  // unbiased exponent
  } operand_t;

endpackage

[rtl/hfm_unpack.sv]
// ----------------------------------------------------------------------------
// hfm_unpack
// Classifies a binary16 operand and normalizes its significand.
// ----------------------------------------------------------------------------
module hfm_unpack (
  input  logic [15:0]       bits_i,
  output hfm_pkg::operand_t opnd_o
);
  import hfm_pkg::*;

  logic [ExpW-1:0]  e;
  logic [FracW-1:0] f;
  logic [3:0]       lz;
  logic [SigW-1:0]  sub_sig;

  assign e = bits_i[14:10];
  assign f = bits_i[9:0];

  // Leading zero count of the fraction, for subnormals
  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < FracW; i++) begin
      if (f[i]) begin
        lz = 4'(FracW - 1 - i);
      end
    end
  end

  // Shift the top set bit up to the hidden-bit position
  assign sub_sig = SigW'({1'b0, f} << (lz + 4'd1));

  always_comb begin
    opnd_o.is_nan  = (e == '1) && (f != '0);
    opnd_o.is_inf  = (e == '1) && (f == '0);
    opnd_o.is_zero = (e == '0) && (f == '0);
    if (e == '0) begin
      opnd_o.sig  = sub_sig;
      opnd_o.expo = -EW'(signed'(7'd15)) - EW'(signed'({3'b0, lz}));
    end else begin
      opnd_o.sig  = {1'b1, f};
      opnd_o.expo = EW'(signed'({2'b0, e})) - EW'(signed'(7'd15));
    end
  end

endmodule

[rtl/half_float_multiplier_top.sv]
// ----------------------------------------------------------------------------
// half_float_multiplier_top
// binary16 multiply with four rounding modes, four register stages.
// ----------------------------------------------------------------------------
// Stages, in order: unpack, multiply, align, round/pack, each stage
// holding one item.
// Throughput: one beat per cycle; a stalled stage holds its item and
// empty stages upstream keep filling.
// Reset: all stage valid bits clear, rounding mode returns to nearest even.
module half_float_multiplier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,     // rounding_mode
  // operand stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] lhs_bits, [31:16] rhs_bits
  // product stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] product_bits
);
  import hfm_pkg::*;

  logic [1:0] rmode_q;

  // Rounding mode register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmode_q <= RM_RESET;
    end else if (cfg_valid_i) begin
      rmode_q <= cfg_data_i;
    end
  end

  // Per-stage flow control
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || m_axis_tready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // ---------------- Stage 1: unpack and classify ----------------
  logic [15:0] a, b;
  operand_t    opa, opb;
  logic        sign_d;
  logic        sp_d;
  logic [15:0] spval_d;

  assign a = s_axis_tdata[15:0];
  assign b = s_axis_tdata[31:16];

  hfm_unpack u_unpack_a (.bits_i(a), .opnd_o(opa));
  hfm_unpack u_unpack_b (.bits_i(b), .opnd_o(opb));

  assign sign_d = a[15] ^ b[15];

  // Special operands, NaN of the left operand first
  always_comb begin
    sp_d    = 1'b1;
    spval_d = '0;
    priority if (opa.is_nan) begin
      spval_d = a;
    end else if (opb.is_nan) begin
      spval_d = b;
    end else if ((opa.is_zero && opb.is_inf) || (opa.is_inf && opb.is_zero)) begin
      spval_d = HF_ZERO_X_INF;
    end else if (opa.is_zero || opb.is_zero) begin
      spval_d = {sign_d, 15'd0};
    end else if (opa.is_inf || opb.is_inf) begin
      spval_d = {sign_d, HF_INF[14:0]};
    end else begin
      sp_d = 1'b0;
    end
  end

  logic                 sp1_q, sign1_q;
  logic [15:0]          spval1_q;
  logic [SigW-1:0]      siga1_q, sigb1_q;
  logic signed [EW-1:0] esum1_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      sp1_q    <= sp_d;
      spval1_q <= spval_d;
      sign1_q  <= sign_d;
      siga1_q  <= opa.sig;
      sigb1_q  <= opb.sig;
      esum1_q  <= opa.expo + opb.expo;
    end
  end

  // ---------------- Stage 2: significand product ----------------
  logic                 sp2_q, sign2_q;
  logic [15:0]          spval2_q;
  logic signed [EW-1:0] esum2_q;
  logic [ProdW-1:0]     prod2_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      sp2_q    <= sp1_q;
      spval2_q <= spval1_q;
      sign2_q  <= sign1_q;
      esum2_q  <= esum1_q;
      prod2_q  <= ProdW'(siga1_q) * ProdW'(sigb1_q);
    end
  end

  // ---------------- Stage 3: exponent and alignment ----------------
  logic                 hi;
  logic signed [7:0]    expr, esum_x, sh_w;
  logic                 tiny;
  logic [4:0]           sh;
  logic [4:0]           sh_m1;
  logic [23:0]          pw, mask;
  logic [11:0]          kept_d;
  logic                 rbit_d, sticky_d;
  logic [5:0]           qb14_d;

  assign hi     = prod2_q[ProdW-1];
  assign esum_x = 8'(esum2_q);
  assign expr   = esum_x + 8'(signed'({1'b0, hi}));
  assign tiny   = expr < -8'sd14;
  assign pw     = {2'b00, prod2_q};

  // Right shift that lands the result on the subnormal quantum when tiny
  always_comb begin
    sh_w = -8'sd4 - esum_x;
    if (!tiny) begin
      sh = 5'd10 + {4'd0, hi};
    end else if (sh_w > 8'sd24) begin
      sh = 5'd24;
    end else begin
      sh = sh_w[4:0];
    end
  end

  assign sh_m1    = sh - 5'd1;
  assign mask     = (24'd1 << sh_m1) - 24'd1;
  assign kept_d   = 12'(pw >> sh);
  assign rbit_d   = pw[sh_m1];
  assign sticky_d = |(pw & mask);
  assign qb14_d   = tiny ? 6'd0 : 6'(expr + 8'sd14);

  logic        sp3_q, sign3_q, rbit3_q, sticky3_q;
  logic [15:0] spval3_q;
  logic [11:0] kept3_q;
  logic [5:0]  qb14_3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      sp3_q     <= sp2_q;
      spval3_q  <= spval2_q;
      sign3_q   <= sign2_q;
      kept3_q   <= kept_d;
      rbit3_q   <= rbit_d;
      sticky3_q <= sticky_d;
      qb14_3_q  <= qb14_d;
    end
  end

  // ---------------- Stage 4: round and pack ----------------
  logic        inc, to_inf;
  logic [12:0] kept_r;
  logic [16:0] mag;
  logic [15:0] res_d;

  always_comb begin
    unique case (rmode_q)
      RM_RTZ: begin
        inc    = 1'b0;
        to_inf = 1'b0;
      end
      RM_RNE: begin
        inc    = rbit3_q && (sticky3_q || kept3_q[0]);
        to_inf = 1'b1;
      end
      RM_RUP: begin
        inc    = (rbit3_q || sticky3_q) && !sign3_q;
        to_inf = !sign3_q;
      end
      RM_RDN: begin
        inc    = (rbit3_q || sticky3_q) && sign3_q;
        to_inf = sign3_q;
      end
      default: begin
        inc    = 1'b0;
        to_inf = 1'b0;
      end
    endcase
  end

  assign kept_r = {1'b0, kept3_q} + {12'd0, inc};
  assign mag    = {1'b0, qb14_3_q, 10'd0} + {4'd0, kept_r};

  always_comb begin
    if (sp3_q) begin
      res_d = spval3_q;
    end else if (mag >= {1'b0, HF_INF}) begin
      res_d = {sign3_q, to_inf ? HF_INF[14:0] : HF_MAX_FINITE[14:0]};
    end else begin
      res_d = {sign3_q, mag[14:0]};
    end
  end

  logic [15:0] res4_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      res4_q <= res_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = res4_q;

endmodule

[dv/tb_half_float_multiplier_top.sv]
// ----------------------------------------------------------------------------
// tb_half_float_multiplier_top
// Self-checking bench for the binary16 multiplier with rounding modes.
// Operand beats are fed in random bursts while the product side stalls on a
// shifting ready pattern. Every accepted beat is run through a bit-exact
// binary16 product predictor, and each product beat is compared in order.
// The rounding mode is rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_half_float_multiplier_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hfm_pkg::*;

  // Expected-product store and binary16 product predictor
  class product_scoreboard;
    logic [1:0]  rounding_mode;
    logic [15:0] expected_products[$];
    int unsigned mismatches;
    int unsigned operands_seen;
    int unsigned products_checked;

    function new();
      rounding_mode = RM_RESET;
    endfunction

    function int unsigned pending();
      return expected_products.size();
    endfunction

    // Finite nonzero magnitude to 11-bit significand with the hidden bit set
    function void normalize(input logic [15:0] v, output logic [10:0] sig, output int ex);
      logic [10:0] frac;
      int          k;
      frac = {1'b0, v[9:0]};
      if (v[14:10] == 5'd0) begin
        k = -14;
        while (frac[10] == 1'b0) begin
          frac = frac << 1;
          k--;
        end
        sig = frac;
        ex  = k;
      end else begin
        sig = {1'b1, v[9:0]};
        ex  = int'(v[14:10]) - 15;
      end
    endfunction

    function logic [15:0] predict_product(logic [15:0] lhs, logic [15:0] rhs);
      logic        sign, l_nan, r_nan, l_inf, r_inf, l_zero, r_zero;
      logic        rnd, sticky, bump, to_inf;
      logic [10:0] lsig, rsig;
      logic [63:0] prod, kept;
      int          lexp, rexp, pexp, qexp, shift;
      int unsigned mag;
      sign   = lhs[15] ^ rhs[15];
      l_nan  = (lhs[14:10] == 5'h1F) && (lhs[9:0] != 10'd0);
      r_nan  = (rhs[14:10] == 5'h1F) && (rhs[9:0] != 10'd0);
      l_inf  = (lhs[14:10] == 5'h1F) && (lhs[9:0] == 10'd0);
      r_inf  = (rhs[14:10] == 5'h1F) && (rhs[9:0] == 10'd0);
      l_zero = (lhs[14:0] == 15'd0);
      r_zero = (rhs[14:0] == 15'd0);
      // special operands: NaN passes through untouched, left side wins
      if (l_nan) return lhs;
      if (r_nan) return rhs;
      if ((l_zero && r_inf) || (l_inf && r_zero)) return HF_ZERO_X_INF;
      if (l_zero || r_zero) return {sign, 15'd0};
      if (l_inf || r_inf) return HF_INF | {sign, 15'd0};

      normalize(lhs, lsig, lexp);
      normalize(rhs, rsig, rexp);
      prod = 64'(lsig) * 64'(rsig);
      pexp = lexp + rexp + (prod[21] ? 1 : 0);
      // tiny results are quantized at 2^-24
      qexp  = (pexp < -14) ? -14 : pexp;
      shift = qexp - lexp - rexp + 10;
      if (shift > 24) shift = 24;
      kept   = prod >> shift;
      rnd    = prod[shift-1];
      sticky = (prod & ((64'd1 << (shift - 1)) - 64'd1)) != 64'd0;
      case (rounding_mode)
        RM_RNE:  bump = rnd && (sticky || kept[0]);
        RM_RUP:  bump = (rnd || sticky) && !sign;
        RM_RDN:  bump = (rnd || sticky) && sign;
        default: bump = 1'b0;
      endcase
      kept = kept + 64'(bump);
      mag  = (unsigned'(qexp + 14) << 10) + 32'(kept);
      // overflow: infinity under nearest even or when rounding away from zero, else largest finite
      if (mag >= 32'(HF_INF)) begin
        to_inf = (rounding_mode == RM_RNE) || (rounding_mode == RM_RUP && !sign) ||
                 (rounding_mode == RM_RDN && sign);
        return (to_inf ? HF_INF : HF_MAX_FINITE) | {sign, 15'd0};
      end
      return {sign, mag[14:0]};
    endfunction

    function void note_operands(logic [15:0] lhs, logic [15:0] rhs);
      expected_products.push_back(predict_product(lhs, rhs));
      operands_seen++;
    endfunction

    function void check_product(logic [15:0] actual);
      logic [15:0] want;
      if (expected_products.size() == 0) begin
        $error("product_bits expected none actual %h", actual);
        mismatches++;
        return;
      end
      want = expected_products.pop_front();
      products_checked++;
      if (actual !== want) begin
        $error("product_bits expected %h actual %h", want, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] lhs_bits, [31:16] rhs_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] product_bits

  product_scoreboard sb = new();
  int unsigned burst_left;
  logic [3:0]  modes_seen;

  half_float_multiplier_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #400_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Product side: check each beat, then stall on a rotating pattern
  initial begin : product_sink
    logic [15:0] ready_pattern;
    int unsigned pattern_age;
    ready_pattern = 16'hFFFF;
    pattern_age   = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_product(m_axis_tdata);
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       ready_pattern = 16'hFFFF;
          1:       ready_pattern = 16'($urandom);
          default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
        endcase
      end
      pattern_age--;
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      m_axis_tready <= ready_pattern[0];
    end
  end

  // Random binary16 operand, weighted toward special and boundary values
  function automatic logic [15:0] random_half();
    logic       s;
    logic [4:0] e;
    logic [9:0] f;
    s = 1'($urandom_range(0, 1));
    f = 10'($urandom);
    e = 5'($urandom_range(1, 30));
    case ($urandom_range(0, 11))
      0: return {s, 15'd0};
      1: return {s, 5'h1F, 10'd0};
      2: return {s, 5'h1F, (f == 10'd0) ? 10'h200 : f};
      3: return {s, 5'd0, f >> $urandom_range(0, 9)};
      4, 5: e = $urandom_range(0, 1) ? 5'($urandom_range(1, 4)) : 5'($urandom_range(26, 30));
      6, 7: f = f & 10'($urandom) & 10'($urandom);  // sparse fraction, more exact ties
      default: return 16'($urandom);
    endcase
    return {s, e, f};
  endfunction

  // One operand beat; bursts of random length separated by random gaps
  task automatic send_operands(input logic [15:0] lhs, input logic [15:0] rhs);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rhs, lhs};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_operands(lhs, rhs);
    burst_left--;
  endtask

  // Drop valid and wait until every expected product has come back
  task automatic drain_products(input int unsigned max_cycles);
    int unsigned waited;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    waited     = 0;
    while (sb.pending() != 0 && waited < max_cycles) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0) begin
      $error("product_bits expected %h actual none (%0d outstanding)",
             sb.expected_products[0], sb.pending());
      sb.mismatches += sb.pending();
      sb.expected_products.delete();
    end
  endtask

  // Register write, only with the pipeline empty
  task automatic write_rounding_mode(input logic [1:0] mode);
    drain_products(5000);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.rounding_mode = mode;
    modes_seen[mode] = 1'b1;
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus
  initial begin : stimulus
    logic [15:0] directed_lhs[$];
    logic [15:0] directed_rhs[$];
    logic [1:0]  phase_modes[8];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = RM_RESET;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    burst_left    = 0;
    modes_seen    = 4'b0010;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: signed zeros, zero times infinity, NaN order, overflow,
    // subnormal operands and underflow ties, all-ones and all-zeros fields
    directed_lhs = '{16'h0000, 16'h8000, 16'h7C00, 16'h0000, 16'hFC00, 16'h7E01,
                     16'h3C00, 16'h7C01, 16'h7C00, 16'h7BFF, 16'hFBFF, 16'h7BFF,
                     16'h0001, 16'h0001, 16'h0001, 16'h0003, 16'h03FF, 16'h0400,
                     16'hFFFF, 16'h3555, 16'hBC00, 16'h0200};
    directed_rhs = '{16'h0000, 16'h3C00, 16'hFC00, 16'h7C00, 16'h8000, 16'h7D00,
                     16'hFD55, 16'h0000, 16'hC000, 16'h7BFF, 16'h7BFF, 16'h3C00,
                     16'h0001, 16'h3C00, 16'h3800, 16'h3800, 16'h3C01, 16'h3BFF,
                     16'h0001, 16'h3555, 16'h3C00, 16'h6400};
    foreach (directed_lhs[i]) send_operands(directed_lhs[i], directed_rhs[i]);

    // Random phases, each under its own rounding mode
    phase_modes = '{RM_RTZ, RM_RUP, RM_RDN, RM_RNE,
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
    foreach (phase_modes[p]) begin
      write_rounding_mode(phase_modes[p]);
      repeat (110) send_operands(random_half(), random_half());
    end

    drain_products(5000);
    repeat (16) @(posedge clk_i);

    $display("Run covered %0d operand beats and %0d checked products.",
             sb.operands_seen, sb.products_checked);
    $display("Rounding modes exercised (bit per mode, RDN..RTZ): %b", modes_seen);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
